// File: hw/rtl/mail_body_qp_dot_stuff_encoder_macros.svh
// Assertion macros for the mail body quoted-printable encoder.
// Expects clk_i and rst_ni in the scope of each use; no other dependencies.
`ifndef MAIL_BODY_QP_DOT_STUFF_ENCODER_MACROS_SVH
`define MAIL_BODY_QP_DOT_STUFF_ENCODER_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define QPDS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define QPDS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/qpds_pkg.sv
// Shared types, character codes and helpers for the quoted-printable encoder.
// No dependencies.
package qpds_pkg;

  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SP    = 8'd32;
  localparam logic [7:0] CH_DOT   = 8'd46;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_TWO   = 8'd50;
  localparam logic [7:0] CH_EQ    = 8'd61;
  localparam logic [7:0] PRINT_LO = 8'd33;
  localparam logic [7:0] PRINT_HI = 8'd126;

  localparam logic [7:0] HEX_CHARS [16] = '{
    8'd48, 8'd49, 8'd50, 8'd51, 8'd52, 8'd53, 8'd54, 8'd55,
    8'd56, 8'd57, 8'd65, 8'd66, 8'd67, 8'd68, 8'd69, 8'd70
  };

  // Output slots of one word: held space (3), own encoding (3), closing CR LF (2).
  localparam int unsigned NUM_SLOTS = 8;
  localparam int unsigned SLOT_W    = $clog2(NUM_SLOTS);

  localparam logic [SLOT_W-1:0] SLOT_PRE0  = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_PRE1  = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_PRE2  = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_MAIN0 = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_MAIN1 = 3'd4;
  localparam logic [SLOT_W-1:0] SLOT_MAIN2 = 3'd5;
  localparam logic [SLOT_W-1:0] SLOT_TAIL0 = 3'd6;
  localparam logic [SLOT_W-1:0] SLOT_TAIL1 = 3'd7;

  localparam logic [NUM_SLOTS-1:0] MASK_PRE_SPACE = 8'b0000_0001;
  localparam logic [NUM_SLOTS-1:0] MASK_PRE_ESC   = 8'b0000_0111;
  localparam logic [NUM_SLOTS-1:0] MASK_MAIN1     = 8'b0000_1000;
  localparam logic [NUM_SLOTS-1:0] MASK_MAIN2     = 8'b0001_1000;
  localparam logic [NUM_SLOTS-1:0] MASK_MAIN3     = 8'b0011_1000;
  localparam logic [NUM_SLOTS-1:0] MASK_TAIL      = 8'b1100_0000;

  localparam int unsigned JOB_QDEPTH = 2;
  localparam int unsigned JOB_QPTR_W = $clog2(JOB_QDEPTH);
  localparam int unsigned JOB_QCNT_W = $clog2(JOB_QDEPTH + 1);

  typedef enum logic [1:0] {
    MAIN_PASS,
    MAIN_DOT2,
    MAIN_ESC,
    MAIN_CRLF
  } main_kind_e;

  typedef struct packed {
    logic [NUM_SLOTS-1:0] mask;
    logic                 pre_esc;
    main_kind_e           kind;
    logic [7:0]           data;
  } qpds_job_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    return HEX_CHARS[nib];
  endfunction

endpackage

// File: hw/rtl/qpds_ifs.sv
// Valid/ready channel interfaces for the encoder's body input and encoded output.
// No dependencies.
interface qpds_body_if;
  logic       valid;
  logic       ready;
  logic [7:0] body_byte;
  logic       body_end;

  modport source (output valid, body_byte, body_end, input ready);
  modport sink   (input valid, body_byte, body_end, output ready);
endinterface

interface qpds_enc_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, out_byte, run_last, input ready);
  modport sink   (input valid, out_byte, run_last, output ready);
endinterface

// File: hw/rtl/qpds_front.sv
// Front end: accepts body words, tracks line and held-space state, emits job descriptors.
// Depends on qpds_pkg, qpds_body_if and the assertion macros.
`include "mail_body_qp_dot_stuff_encoder_macros.svh"

module qpds_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  qpds_body_if.sink           body_i,
  input  logic                q_full_i,
  output logic                push_o,
  output qpds_pkg::qpds_job_t job_o
);
  import qpds_pkg::*;

  logic       line_start_q, line_start_d;
  logic       space_q, space_d;
  logic       accept;
  logic [7:0] b;
  logic       last;
  logic       line_eff;
  logic       line_after;
  logic       crlf_in;
  logic       printable;
  logic [NUM_SLOTS-1:0] mask;

  assign body_i.ready = !q_full_i;
  assign accept       = body_i.valid && body_i.ready;
  assign b            = body_i.body_byte;
  assign last         = body_i.body_end;

  always_comb begin
    crlf_in   = (b == CH_CR) || (b == CH_LF);
    printable = (b >= PRINT_LO) && (b <= PRINT_HI) && (b != CH_EQ);
    // a held space counts as written, so the line is no longer at its start
    line_eff  = space_q ? 1'b0 : line_start_q;
    mask      = '0;
    job_o.kind    = MAIN_PASS;
    job_o.data    = b;
    job_o.pre_esc = crlf_in;
    line_after    = 1'b0;
    space_d       = space_q;
    line_start_d  = line_start_q;

    if (space_q) begin
      mask = crlf_in ? MASK_PRE_ESC : MASK_PRE_SPACE;
    end

    if ((b == CH_DOT) && line_eff) begin
      job_o.kind = MAIN_DOT2;
      mask       = mask | MASK_MAIN2;
    end else if (printable) begin
      job_o.kind = MAIN_PASS;
      mask       = mask | MASK_MAIN1;
    end else if (b == CH_SP) begin
      if (last) begin
        job_o.kind = MAIN_ESC;
        mask       = mask | MASK_MAIN3;
      end
    end else if (b == CH_CR) begin
      line_after = line_eff;
    end else if (b == CH_LF) begin
      job_o.kind = MAIN_CRLF;
      mask       = mask | MASK_MAIN2;
      line_after = 1'b1;
    end else begin
      job_o.kind = MAIN_ESC;
      mask       = mask | MASK_MAIN3;
    end

    if (last && !line_after) begin
      mask = mask | MASK_TAIL;
    end

    job_o.mask = mask;
    push_o     = accept && (mask != '0);

    if (accept) begin
      if (last) begin
        line_start_d = 1'b1;
        space_d      = 1'b0;
      end else begin
        line_start_d = line_after;
        space_d      = (b == CH_SP);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_start_q <= 1'b1;
      space_q      <= 1'b0;
    end else begin
      line_start_q <= line_start_d;
      space_q      <= space_d;
    end
  end

  `QPDS_ASSERT(a_held_space_mid_line, !(space_q && line_start_q), "held space at line start")

endmodule

// File: hw/rtl/qpds_fifo.sv
// Short job queue between front and back end, built from registers.
// Depends on qpds_pkg and the assertion macros.
`include "mail_body_qp_dot_stuff_encoder_macros.svh"

module qpds_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  qpds_pkg::qpds_job_t job_i,
  input  logic                pop_i,
  output qpds_pkg::qpds_job_t job_o,
  output logic                full_o,
  output logic                empty_o
);
  import qpds_pkg::*;

  qpds_job_t             mem_q [JOB_QDEPTH];
  logic [JOB_QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [JOB_QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [JOB_QCNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == JOB_QCNT_W'(JOB_QDEPTH));
  assign empty_o = (count_q == '0);
  assign job_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == JOB_QPTR_W'(JOB_QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == JOB_QPTR_W'(JOB_QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  `QPDS_ASSERT(a_no_push_when_full, !push_i || !full_o, "push into full job queue")
  `QPDS_ASSERT(a_no_pop_when_empty, !pop_i || !empty_o, "pop from empty job queue")

endmodule

// File: hw/rtl/qpds_back.sv
// Back end: expands job descriptors into output characters, one per cycle while enc_o is
// ready, into an output register. Depends on qpds_pkg, qpds_enc_if and the assertion macros.
`include "mail_body_qp_dot_stuff_encoder_macros.svh"

module qpds_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  qpds_pkg::qpds_job_t job_i,
  input  logic                q_empty_i,
  output logic                pop_o,
  qpds_enc_if.source          enc_o
);
  import qpds_pkg::*;

  logic [NUM_SLOTS-1:0] mask_q, mask_d;
  logic                 pre_esc_q;
  main_kind_e           kind_q;
  logic [7:0]           data_q;
  logic                 out_valid_q, out_valid_d;
  logic [7:0]           out_byte_q, out_byte_d;
  logic                 out_last_q, out_last_d;

  logic [NUM_SLOTS-1:0] low_bit;
  logic [NUM_SLOTS-1:0] rest;
  logic [SLOT_W-1:0]    slot;
  logic [7:0]           slot_byte;
  logic                 free;
  logic                 emit;
  logic                 done;

  always_comb begin
    low_bit = mask_q & (~mask_q + 1'b1);
    rest    = mask_q & ~low_bit;
    slot    = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (low_bit[i]) begin
        slot = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    unique case (slot)
      SLOT_PRE0:  slot_byte = pre_esc_q ? CH_EQ : CH_SP;
      SLOT_PRE1:  slot_byte = CH_TWO;
      SLOT_PRE2:  slot_byte = CH_ZERO;
      SLOT_MAIN0: begin
        case (kind_q)
          MAIN_DOT2: slot_byte = CH_DOT;
          MAIN_ESC:  slot_byte = CH_EQ;
          MAIN_CRLF: slot_byte = CH_CR;
          default:   slot_byte = data_q;
        endcase
      end
      SLOT_MAIN1: begin
        case (kind_q)
          MAIN_DOT2: slot_byte = CH_DOT;
          MAIN_CRLF: slot_byte = CH_LF;
          default:   slot_byte = hex_char(data_q[7:4]);
        endcase
      end
      SLOT_MAIN2: slot_byte = hex_char(data_q[3:0]);
      SLOT_TAIL0: slot_byte = CH_CR;
      SLOT_TAIL1: slot_byte = CH_LF;
      default:    slot_byte = CH_LF;
    endcase
  end

  assign free  = !out_valid_q || enc_o.ready;
  assign emit  = free && (mask_q != '0);
  // load the next job as the current one finishes, so jobs follow without a gap
  assign done  = (mask_q == '0) || (emit && (rest == '0));
  assign pop_o = done && !q_empty_i;

  always_comb begin
    mask_d      = mask_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    if (emit) begin
      mask_d      = rest;
      out_valid_d = 1'b1;
      out_byte_d  = slot_byte;
      out_last_d  = (rest == '0);
    end else if (enc_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (pop_o) begin
      mask_d = job_i.mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    if (pop_o) begin
      pre_esc_q <= job_i.pre_esc;
      kind_q    <= job_i.kind;
      data_q    <= job_i.data;
    end
  end

  assign enc_o.valid    = out_valid_q;
  assign enc_o.out_byte = out_byte_q;
  assign enc_o.run_last = out_last_q;

  `QPDS_ASSERT_NEXT(a_last_on_final_slot, emit && ($countones(mask_q) == 1), out_valid_q && out_last_q, "final character not marked last")
  `QPDS_ASSERT_NEXT(a_no_early_last, emit && ($countones(mask_q) > 1), out_valid_q && !out_last_q, "last mark before final character")

endmodule

// File: hw/rtl/mail_body_qp_dot_stuff_encoder.sv
// Mail body encoder: quoted-printable with SMTP dot-stuffing, no soft line breaks.
// Input channel body_i carries one raw body byte per word with body_end on the final
// byte of a body; output channel enc_o carries one encoded character per word, with
// run_last on the last character caused by an input word. Both are valid/ready; a
// word moves when valid and ready are both high.
// A word yields zero to six characters: a dropped CR or a newly held space gives
// none, and a held space is emitted ahead of the next word's own characters.
// An accepted word passes the job queue and the back-end job register before its first
// character is registered. The back end sends one character per cycle while enc_o is
// ready, so throughput is set by the characters per word: one word per cycle for plain
// text, less for escaped bytes. A two-entry job queue lets input run ahead of output.
// When the receiver stalls, the output register holds its character, the queue fills
// and body_i.ready drops; nothing is lost.
// Reset (rst_ni, asynchronous, active low) empties the queue and the output register
// and returns to the start of a line with no held space; the block is ready at once.
// Depends on qpds_pkg, the channel interfaces, qpds_front, qpds_fifo and qpds_back.
module mail_body_qp_dot_stuff_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  qpds_body_if.sink  body_i,
  qpds_enc_if.source enc_o
);
  import qpds_pkg::*;

  qpds_job_t push_job;
  qpds_job_t head_job;
  logic      push;
  logic      pop;
  logic      q_full;
  logic      q_empty;

  qpds_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .body_i   (body_i),
    .q_full_i (q_full),
    .push_o   (push),
    .job_o    (push_job)
  );

  qpds_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (head_job),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  qpds_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .job_i     (head_job),
    .q_empty_i (q_empty),
    .pop_o     (pop),
    .enc_o     (enc_o)
  );

endmodule

// File: tb/sv/qpds_enc_checker.sv
// Scoreboard for the mail body encoder: watches the body and encoded channels,
// predicts the encoded characters of every accepted body word and compares them.
// Depends on qpds_pkg and the channel interfaces in qpds_ifs.sv.
module qpds_enc_checker (
  input  logic  clk_i,
  input  logic  rst_ni,
  qpds_body_if  body_i,
  qpds_enc_if   enc_i,
  output int    fail_count_o,
  output int    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import qpds_pkg::*;

  // 'A' minus ten, so that nibble 10 maps onto 'A'
  localparam logic [7:0] HEX_ALPHA_BASE = 8'd55;

  typedef struct packed {
    logic [7:0] ch;
    logic       run_last;
  } enc_char_t;

  enc_char_t expected_chars [$];
  enc_char_t run_chars [$];
  logic      at_line_start;
  logic      space_held;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    return (nib < 4'd10) ? CH_ZERO + 8'(nib) : HEX_ALPHA_BASE + 8'(nib);
  endfunction

  function void push_char(input logic [7:0] ch);
    run_chars.push_back('{ch: ch, run_last: 1'b0});
  endfunction

  function void push_escape(input logic [7:0] ch);
    push_char(CH_EQ);
    push_char(hex_digit(ch[7:4]));
    push_char(hex_digit(ch[3:0]));
  endfunction

  // Work out the characters one body word causes and queue them.
  function void encode_body_byte(input logic [7:0] b, input logic last);
    run_chars.delete();
    if (space_held) begin
      if (b == CH_CR || b == CH_LF) push_escape(CH_SP);
      else push_char(CH_SP);
      space_held    = 1'b0;
      at_line_start = 1'b0;
    end
    if (b == CH_DOT && at_line_start) begin
      push_char(CH_DOT);
      push_char(CH_DOT);
      at_line_start = 1'b0;
    end else if (b >= PRINT_LO && b <= PRINT_HI && b != CH_EQ) begin
      push_char(b);
      at_line_start = 1'b0;
    end else if (b == CH_SP) begin
      if (last) push_escape(CH_SP);
      else space_held = 1'b1;
      at_line_start = 1'b0;
    end else if (b == CH_CR) begin
      // drop
    end else if (b == CH_LF) begin
      push_char(CH_CR);
      push_char(CH_LF);
      at_line_start = 1'b1;
    end else begin
      push_escape(b);
      at_line_start = 1'b0;
    end
    if (last) begin
      if (!at_line_start) begin
        push_char(CH_CR);
        push_char(CH_LF);
      end
      at_line_start = 1'b1;
      space_held    = 1'b0;
    end
    if (run_chars.size() > 0) run_chars[run_chars.size()-1].run_last = 1'b1;
    foreach (run_chars[i]) expected_chars.push_back(run_chars[i]);
  endfunction

  task report_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("%0t ns: %s: got %02h, expected %02h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    enc_char_t want;
    if (!rst_ni) begin
      expected_chars.delete();
      at_line_start = 1'b1;
      space_held    = 1'b0;
    end else begin
      if (body_i.valid && body_i.ready) encode_body_byte(body_i.body_byte, body_i.body_end);
      if (enc_i.valid && enc_i.ready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch("character with none expected", enc_i.out_byte, 8'h00);
        end else begin
          want = expected_chars.pop_front();
          if (enc_i.out_byte !== want.ch)
            report_mismatch("out_byte", enc_i.out_byte, want.ch);
          if (enc_i.run_last !== want.run_last)
            report_mismatch("run_last", 8'(enc_i.run_last), 8'(want.run_last));
        end
      end
    end
    pending_o = expected_chars.size();
  end

endmodule

// File: tb/sv/tb_mail_body_qp_dot_stuff_encoder.sv
// Testbench top for the mail body encoder: clock, reset, body stimulus and
// output back-pressure; checking is done by qpds_enc_checker.
// Depends on qpds_pkg, qpds_ifs.sv, qpds_enc_checker and the encoder RTL.
module tb_mail_body_qp_dot_stuff_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  import qpds_pkg::*;

  localparam int NUM_RANDOM_WORDS = 300;
  localparam int DRAIN_CYCLES     = 12;

  logic clk;
  logic rst_n;
  logic no_idle;
  int   fail_count;
  int   pending;
  int   words_sent;

  qpds_body_if body_if ();
  qpds_enc_if  enc_if ();

  mail_body_qp_dot_stuff_encoder dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .body_i (body_if),
    .enc_o  (enc_if)
  );

  qpds_enc_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .body_i       (body_if),
    .enc_i        (enc_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #5_000_000;
    $display("mail_body_qp_dot_stuff_encoder test failed");
    $finish;
  end

  // Present one body word from the falling edge and hold it until taken.
  task send_word(input logic [7:0] b, input logic last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      body_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    body_if.valid     <= 1'b1;
    body_if.body_byte <= b;
    body_if.body_end  <= last;
    do @(posedge clk); while (!body_if.ready);
    @(negedge clk);
    words_sent++;
  endtask

  function automatic logic [7:0] pick_body_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 8'($urandom_range(PRINT_LO, PRINT_HI));
    if (r < 60) return CH_SP;
    if (r < 68) return CH_DOT;
    if (r < 76) return CH_CR;
    if (r < 86) return CH_LF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Output back-pressure
  initial begin
    int stall;
    enc_if.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        enc_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      enc_if.ready <= 1'b1;
      do @(posedge clk); while (!enc_if.valid);
      @(negedge clk);
    end
  end

  initial begin
    int       body_len;
    logic     noise;
    logic [7:0] b;
    body_if.valid     = 1'b0;
    body_if.body_byte = 8'h00;
    body_if.body_end  = 1'b0;
    rst_n             = 1'b0;
    no_idle           = 1'b0;
    words_sent        = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // dot stuffing, escapes and field extremes
    send_word(CH_DOT, 1'b0);
    send_word(CH_DOT, 1'b0);
    send_word(CH_EQ, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(PRINT_LO, 1'b0);
    send_word(PRINT_HI, 1'b0);
    send_word(8'd127, 1'b0);
    // held space resolved by text, by another space, by CR and by LF
    send_word(CH_SP, 1'b0);
    send_word(8'h78, 1'b0);
    send_word(CH_SP, 1'b0);
    send_word(CH_SP, 1'b0);
    send_word(CH_CR, 1'b0);
    send_word(CH_LF, 1'b0);
    send_word(CH_SP, 1'b0);
    send_word(CH_LF, 1'b0);
    send_word(CH_DOT, 1'b0);
    send_word(CH_SP, 1'b0);
    send_word(8'h09, 1'b1);
    // single-word bodies: space, LF, dot, dropped CR at line start
    send_word(CH_SP, 1'b1);
    send_word(CH_LF, 1'b1);
    send_word(CH_DOT, 1'b1);
    send_word(CH_CR, 1'b1);
    send_word(8'h5A, 1'b0);
    send_word(CH_CR, 1'b1);

    // random bodies, mostly text-like, some raw noise
    words_sent = 0;
    while (words_sent < NUM_RANDOM_WORDS) begin
      no_idle  = ($urandom_range(0, 3) == 0);
      noise    = ($urandom_range(0, 7) == 0);
      body_len = $urandom_range(1, 16);
      for (int i = 0; i < body_len; i++) begin
        b = noise ? 8'($urandom_range(0, 255)) : pick_body_byte();
        if (noise) send_word(b, 1'($urandom_range(0, 9) == 0) || i == body_len - 1);
        else send_word(b, i == body_len - 1);
      end
    end
    no_idle = 1'b0;
    body_if.valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("mail_body_qp_dot_stuff_encoder test passed");
    end else begin
      $display("mail_body_qp_dot_stuff_encoder test failed");
    end
    $finish;
  end

endmodule
